/* hdl/button_knob_led_i2c_peripheral_top_defines.svh */
// Assertion macros used by the front-panel peripheral top level.
`ifndef BUTTON_KNOB_LED_I2C_PERIPHERAL_TOP_DEFINES_SVH
`define BUTTON_KNOB_LED_I2C_PERIPHERAL_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define BKL_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bkl assertion failed");
`define BKL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bkl assertion failed");
`else
`define BKL_ASSERT_IMPL(label, ante, cons)
`define BKL_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* hdl/bkl_pkg.sv */
// Shared constants and types for the front-panel peripheral.
package bkl_pkg;

  localparam int NUM_BUTTONS_DEF = 13;
  localparam int NUM_KNOBS_DEF   = 6;
  localparam int LED_BYTES_DEF   = 15;
  localparam int OUT_BYTES       = 8;
  localparam int OUT_PTR_W       = 3;
  localparam int BTN_PAD_W       = 16;

  localparam logic [7:0] DEBOUNCE_RESET = 8'd25;
  localparam logic [7:0] LED_RESET      = 8'h01;
  localparam logic [7:0] BTN_BYTE_RESET = 8'hFF;
  localparam logic [2:0] KNOB_BASE      = 3'd2;

  typedef logic [BTN_PAD_W-1:0] btn_pad_t;

  typedef enum logic [2:0] {
    REQ_TICK  = 3'd0,
    REQ_WRITE = 3'd1,
    REQ_READ  = 3'd2,
    REQ_KNOB  = 3'd3,
    REQ_FETCH = 3'd4
  } req_t;

endpackage

/* hdl/bkl_debounce.sv */
// Parallel button debouncers with per-button lockout counters.
module bkl_debounce #(
  parameter int NUM_BUTTONS = bkl_pkg::NUM_BUTTONS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   tick_en,
  input  logic [NUM_BUTTONS-1:0] raw,
  input  logic [7:0]             ticks,
  output logic [NUM_BUTTONS-1:0] level_nxt,
  output logic                   changed
);

  logic [NUM_BUTTONS-1:0] level_r;
  logic [7:0]             count_r   [NUM_BUTTONS];
  logic [7:0]             count_nxt [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] flip;

  always_comb begin
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      flip[i]      = (count_r[i] == 8'd0) && (raw[i] != level_r[i]);
      level_nxt[i] = flip[i] ? raw[i] : level_r[i];
      if (flip[i]) begin
        count_nxt[i] = ticks;
      end else if (count_r[i] != 8'd0) begin
        count_nxt[i] = count_r[i] - 8'd1;
      end else begin
        count_nxt[i] = count_r[i];
      end
    end
    changed = |flip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '1;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        count_r[i] <= 8'd0;
      end
    end else if (tick_en) begin
      level_r <= level_nxt;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        count_r[i] <= count_nxt[i];
      end
    end
  end

endmodule

/* hdl/button_knob_led_i2c_peripheral_top.sv */
// Top level of the serial-bus front-panel peripheral with button debounce.
//
//   channel  direction  handshake                  payload
//   in_      request    in_valid / in_stall        type, buttons, byte, knob, LED index
//   out_     result     out_valid / out_stall      read data, interrupt level
//   cfg_     register   cfg_wr_en                  debounce lockout ticks
//
// One transaction per cycle is sustained while out_stall is low; each request passes
// through the input register and then the result register.
// The debouncers (on tick requests only), the byte stores and the pointers update
// together when a request advances. Reset is synchronous and active low.
// A stalled result holds in the output register while one further request waits in the
// input register; in_stall rises only when both are occupied.
`include "button_knob_led_i2c_peripheral_top_defines.svh"

module button_knob_led_i2c_peripheral_top #(
  parameter int NUM_BUTTONS = bkl_pkg::NUM_BUTTONS_DEF,
  parameter int NUM_KNOBS   = bkl_pkg::NUM_KNOBS_DEF,
  parameter int LED_BYTES   = bkl_pkg::LED_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [2:0]             in_req_type,
  input  logic [NUM_BUTTONS-1:0] in_raw_buttons,
  input  logic [7:0]             in_write_byte,
  input  logic [2:0]             in_knob_channel,
  input  logic [7:0]             in_knob_value,
  input  logic [3:0]             in_led_index,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             out_read_data,
  output logic                   out_irq,
  input  logic                   cfg_wr_en,
  input  logic [7:0]             cfg_wr_data
);

  localparam int LED_PTR_W = $clog2(LED_BYTES);

  logic                   in_valid_r;
  logic [2:0]             req_r;
  logic [NUM_BUTTONS-1:0] raw_r;
  logic [7:0]             wbyte_r;
  logic [2:0]             chan_r;
  logic [7:0]             kval_r;
  logic [3:0]             lidx_r;

  logic                   out_valid_r;
  logic [7:0]             out_data_r;
  logic                   out_irq_r;

  logic [7:0]             ticks_r;
  logic                   irq_r;
  logic                   irq_nxt;
  logic [LED_PTR_W-1:0]   wr_ptr_r;
  logic [LED_PTR_W-1:0]   wr_ptr_nxt;
  logic [bkl_pkg::OUT_PTR_W-1:0] rd_ptr_r;
  logic [bkl_pkg::OUT_PTR_W-1:0] rd_ptr_nxt;
  logic [7:0]             out_bytes_r   [bkl_pkg::OUT_BYTES];
  logic [7:0]             out_bytes_nxt [bkl_pkg::OUT_BYTES];
  logic [7:0]             led_r   [LED_BYTES];
  logic [7:0]             led_nxt [LED_BYTES];
  logic [7:0]             data_nxt;

  logic                   accept;
  logic                   advance;
  logic                   tick_en;
  logic                   changed;
  logic [NUM_BUTTONS-1:0] level_nxt;
  bkl_pkg::btn_pad_t      level_pad;

  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign tick_en  = advance && (req_r == bkl_pkg::REQ_TICK);

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;
  assign out_irq       = out_irq_r;

  bkl_debounce #(
    .NUM_BUTTONS(NUM_BUTTONS)
  ) u_debounce (
    .clk      (clk),
    .rst_n    (rst_n),
    .tick_en  (tick_en),
    .raw      (raw_r),
    .ticks    (ticks_r),
    .level_nxt(level_nxt),
    .changed  (changed)
  );

  assign level_pad = bkl_pkg::btn_pad_t'(level_nxt);

  always_comb begin
    irq_nxt    = irq_r;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    data_nxt   = 8'd0;
    for (int i = 0; i < bkl_pkg::OUT_BYTES; i++) begin
      out_bytes_nxt[i] = out_bytes_r[i];
    end
    for (int i = 0; i < LED_BYTES; i++) begin
      led_nxt[i] = led_r[i];
    end
    unique case (req_r)
      bkl_pkg::REQ_TICK: begin
        if (changed) begin
          out_bytes_nxt[0] = level_pad[7:0];
          out_bytes_nxt[1] = level_pad[15:8];
          irq_nxt          = 1'b1;
        end
      end
      bkl_pkg::REQ_WRITE: begin
        led_nxt[wr_ptr_r] = wbyte_r;
        if ({1'b0, wr_ptr_r} == (LED_PTR_W+1)'(LED_BYTES - 1)) begin
          wr_ptr_nxt = '0;
        end else begin
          wr_ptr_nxt = wr_ptr_r + LED_PTR_W'(1);
        end
      end
      bkl_pkg::REQ_READ: begin
        irq_nxt    = 1'b0;
        data_nxt   = out_bytes_r[rd_ptr_r];
        rd_ptr_nxt = rd_ptr_r + bkl_pkg::OUT_PTR_W'(1);
      end
      bkl_pkg::REQ_KNOB: begin
        if ({1'b0, chan_r} < 4'(NUM_KNOBS)) begin
          out_bytes_nxt[bkl_pkg::KNOB_BASE + chan_r] = kval_r;
        end
      end
      bkl_pkg::REQ_FETCH: begin
        if ({1'b0, lidx_r} < 5'(LED_BYTES)) begin
          data_nxt = led_r[lidx_r[LED_PTR_W-1:0]];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      ticks_r     <= bkl_pkg::DEBOUNCE_RESET;
      irq_r       <= 1'b0;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      for (int i = 0; i < bkl_pkg::OUT_BYTES; i++) begin
        out_bytes_r[i] <= (i < 2) ? bkl_pkg::BTN_BYTE_RESET : 8'd0;
      end
      for (int i = 0; i < LED_BYTES; i++) begin
        led_r[i] <= bkl_pkg::LED_RESET;
      end
    end else begin
      if (cfg_wr_en) begin
        ticks_r <= cfg_wr_data;
      end
      if (accept) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        irq_r       <= irq_nxt;
        wr_ptr_r    <= wr_ptr_nxt;
        rd_ptr_r    <= rd_ptr_nxt;
        for (int i = 0; i < bkl_pkg::OUT_BYTES; i++) begin
          out_bytes_r[i] <= out_bytes_nxt[i];
        end
        for (int i = 0; i < LED_BYTES; i++) begin
          led_r[i] <= led_nxt[i];
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r   <= in_req_type;
      raw_r   <= in_raw_buttons;
      wbyte_r <= in_write_byte;
      chan_r  <= in_knob_channel;
      kval_r  <= in_knob_value;
      lidx_r  <= in_led_index;
    end
    if (advance) begin
      out_data_r <= data_nxt;
      out_irq_r  <= irq_nxt;
    end
  end

  `BKL_ASSERT_IMPL(a_wr_ptr_range, 1'b1, {1'b0, wr_ptr_r} < (LED_PTR_W+1)'(LED_BYTES))
  `BKL_ASSERT_IMPL(a_stall_needs_full, in_stall, in_valid_r && out_valid_r)
  `BKL_ASSERT_NEXT(a_read_clears_irq, advance && (req_r == bkl_pkg::REQ_READ), !irq_r && !out_irq_r)
  `BKL_ASSERT_NEXT(a_change_sets_irq, tick_en && changed, irq_r && out_irq_r)
  `BKL_ASSERT_NEXT(a_result_loaded, advance, out_valid_r)

endmodule
